/* sv/red_pkg.sv */
// Shared types, constants and arithmetic helpers for the radio energy debit block.
package red_pkg;

  localparam int NODES_DEF = 256;
  localparam int HEADS_DEF = 16;

  localparam int ADDR_W = 6;
  localparam int DATA_W = 64;

  localparam logic [2:0] REG_E_TX      = 3'd0;
  localparam logic [2:0] REG_E_RX      = 3'd1;
  localparam logic [2:0] REG_E_DA      = 3'd2;
  localparam logic [2:0] REG_E_FS      = 3'd3;
  localparam logic [2:0] REG_E_MP      = 3'd4;
  localparam logic [2:0] REG_PKT       = 3'd5;
  localparam logic [2:0] REG_CTRL_PKT  = 3'd6;
  localparam logic [2:0] REG_RX_PKTS   = 3'd7;

  localparam logic [39:0] E_TX_RST = 40'd50000000000;
  localparam logic [39:0] E_RX_RST = 40'd50000000000;
  localparam logic [39:0] E_DA_RST = 40'd5000000000;
  localparam logic [39:0] E_FS_RST = 40'd10000000;
  localparam logic [39:0] E_MP_RST = 40'd1300;
  localparam logic [15:0] PKT_RST  = 16'd4000;
  localparam logic [15:0] CTRL_RST = 16'd100;
  localparam logic [7:0]  RXP_RST  = 8'd10;

  localparam logic [2:0] KIND_SET    = 3'd0;
  localparam logic [2:0] KIND_ROUND  = 3'd1;
  localparam logic [2:0] KIND_ADD    = 3'd2;
  localparam logic [2:0] KIND_HDEBIT = 3'd3;
  localparam logic [2:0] KIND_MDEBIT = 3'd4;
  localparam logic [2:0] KIND_READ   = 3'd5;

  // energy is stored offset by the floor, so the floor is zero
  localparam logic [62:0] EN_FLOOR = 63'h4000_0000_0000_0000;

  typedef struct packed {
    logic [39:0] e_tx;
    logic [39:0] e_rx;
    logic [39:0] e_da;
    logic [39:0] e_fs;
    logic [39:0] e_mp;
    logic [15:0] packet_bits;
    logic [15:0] ctrl_packet_bits;
    logic [7:0]  rx_packets;
  } cfg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DISP,
    ST_HEAD_RD,
    ST_EN_RD,
    ST_SCAN,
    ST_MUL_GO,
    ST_MUL_WAIT,
    ST_DEBIT1,
    ST_H_RD,
    ST_H_WAIT,
    ST_OUT
  } st_t;

  function automatic logic [63:0] sadd(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[64] ? '1 : s[63:0];
  endfunction

  function automatic logic [62:0] debit(input logic [62:0] room, input logic [63:0] cost);
    if (cost >= {1'b0, room}) return '0;
    return room - cost[62:0];
  endfunction

endpackage

/* sv/radio_energy_debit_nearest_head.sv */
// Top level: radio energy debit with nearest cluster-head search.
// Set energy, start round, add head and empty-slot head debit go from dispatch straight to the
// output; read and skipped member debit first read the node energy. Head and member debits run
// the shared 64x64 saturating multiplier (four 16-bit digits; seven products for a head debit,
// six for a member debit); a member debit first scans the head table, one entry a cycle.
// busy is high from accept until the done cycle; the next item may start in it.
// rst resets control registers and loads config registers with their defaults; memories are not cleared.
module radio_energy_debit_nearest_head #(
  parameter int NODES = red_pkg::NODES_DEF,
  parameter int HEADS = red_pkg::HEADS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  logic [2:0]                 kind,
  input  logic [7:0]                 node,
  input  logic [9:0]                 x,
  input  logic [9:0]                 y,
  input  logic [20:0]                dist_sq,
  input  logic [3:0]                 slot,
  input  logic signed [62:0]         energy_value,
  input  logic                       member,
  input  logic                       dead,
  output logic                       done,
  output logic [7:0]                 node_out,
  output logic signed [62:0]         energy,
  output logic [7:0]                 head_node,
  output logic signed [62:0]         head_energy,
  output logic                       updated,
  output logic [4:0]                 head_count,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [red_pkg::ADDR_W-1:0] paddr,
  input  logic [red_pkg::DATA_W-1:0] pwdata,
  output logic [red_pkg::DATA_W-1:0] prdata,
  output logic                       pready
);
  import red_pkg::*;

  cfg_t cfg;

  red_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  red_core #(
    .NODES (NODES),
    .HEADS (HEADS)
  ) u_core (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .start        (start),
    .busy         (busy),
    .kind         (kind),
    .node         (node),
    .x            (x),
    .y            (y),
    .dist_sq      (dist_sq),
    .slot         (slot),
    .energy_value (energy_value),
    .member       (member),
    .dead         (dead),
    .done         (done),
    .node_out     (node_out),
    .energy       (energy),
    .head_node    (head_node),
    .head_energy  (head_energy),
    .updated      (updated),
    .head_count   (head_count)
  );

  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("done while busy");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst) start && !busy |=> busy)
    else $error("accepted item did not raise busy");

  a_skip_no_head: assert property (@(posedge clk) disable iff (rst)
    done && !updated |-> head_node == '0 && head_energy == '0)
    else $error("head fields set on a skipped item");

endmodule

/* sv/red_smul.sv */
// Iterative saturating 64x64 multiplier, one 16-bit digit of b per cycle.
module red_smul (
  input  logic        clk,
  input  logic        rst,
  input  logic        go,
  input  logic [63:0] a,
  input  logic [63:0] b,
  output logic        done,
  output logic [63:0] p
);
  import red_pkg::*;

  localparam int DIG  = 16;
  localparam int NDIG = 64 / DIG;

  logic [63:0] aq;
  logic [63:0] bq;
  logic [63:0] acc;
  logic [2:0]  cnt;
  logic [79:0] prod;
  logic [80:0] sum;
  logic        ovf;

  assign prod = 80'(aq) * 80'(bq[63:64-DIG]);
  assign sum  = {1'b0, acc, {DIG{1'b0}}} + {1'b0, prod};
  assign ovf  = (|acc[63:64-DIG]) || (|sum[80:64]);
  assign p    = acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (go) begin
        aq  <= a;
        bq  <= b;
        acc <= '0;
        cnt <= 3'(NDIG);
      end else if (cnt != '0) begin
        acc  <= ovf ? '1 : sum[63:0];
        bq   <= bq << DIG;
        cnt  <= cnt - 3'd1;
        done <= (cnt == 3'd1);
      end
    end
  end

endmodule

/* sv/red_regs.sv */
// Configuration register file behind the APB-style port.
module red_regs (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [red_pkg::ADDR_W-1:0] paddr,
  input  logic [red_pkg::DATA_W-1:0] pwdata,
  output logic [red_pkg::DATA_W-1:0] prdata,
  output logic                       pready,
  output red_pkg::cfg_t              cfg
);
  import red_pkg::*;

  logic [2:0] idx;
  logic       wr;

  assign idx    = paddr[ADDR_W-1:3];
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.e_tx             <= E_TX_RST;
      cfg.e_rx             <= E_RX_RST;
      cfg.e_da             <= E_DA_RST;
      cfg.e_fs             <= E_FS_RST;
      cfg.e_mp             <= E_MP_RST;
      cfg.packet_bits      <= PKT_RST;
      cfg.ctrl_packet_bits <= CTRL_RST;
      cfg.rx_packets       <= RXP_RST;
    end else if (wr) begin
      unique case (idx)
        REG_E_TX:     cfg.e_tx             <= pwdata[39:0];
        REG_E_RX:     cfg.e_rx             <= pwdata[39:0];
        REG_E_DA:     cfg.e_da             <= pwdata[39:0];
        REG_E_FS:     cfg.e_fs             <= pwdata[39:0];
        REG_E_MP:     cfg.e_mp             <= pwdata[39:0];
        REG_PKT:      cfg.packet_bits      <= pwdata[15:0];
        REG_CTRL_PKT: cfg.ctrl_packet_bits <= pwdata[15:0];
        REG_RX_PKTS:  cfg.rx_packets       <= pwdata[7:0];
        default:      ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_E_TX:     prdata = 64'(cfg.e_tx);
      REG_E_RX:     prdata = 64'(cfg.e_rx);
      REG_E_DA:     prdata = 64'(cfg.e_da);
      REG_E_FS:     prdata = 64'(cfg.e_fs);
      REG_E_MP:     prdata = 64'(cfg.e_mp);
      REG_PKT:      prdata = 64'(cfg.packet_bits);
      REG_CTRL_PKT: prdata = 64'(cfg.ctrl_packet_bits);
      REG_RX_PKTS:  prdata = 64'(cfg.rx_packets);
      default:      prdata = '0;
    endcase
  end

endmodule

/* sv/red_core.sv */
// Sequencer with the node energy memory and the cluster-head table.
module red_core #(
  parameter int NODES = red_pkg::NODES_DEF,
  parameter int HEADS = red_pkg::HEADS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  red_pkg::cfg_t      cfg,
  input  logic               start,
  output logic               busy,
  input  logic [2:0]         kind,
  input  logic [7:0]         node,
  input  logic [9:0]         x,
  input  logic [9:0]         y,
  input  logic [20:0]        dist_sq,
  input  logic [3:0]         slot,
  input  logic signed [62:0] energy_value,
  input  logic               member,
  input  logic               dead,
  output logic               done,
  output logic [7:0]         node_out,
  output logic signed [62:0] energy,
  output logic [7:0]         head_node,
  output logic signed [62:0] head_energy,
  output logic               updated,
  output logic [4:0]         head_count
);
  import red_pkg::*;

  localparam int NW  = (NODES > 1) ? $clog2(NODES) : 1;
  localparam int HW  = (HEADS > 1) ? $clog2(HEADS) : 1;
  localparam int LW  = $clog2(HEADS + 1);
  localparam int HEW = NW + 41;

  st_t state, state_next;

  logic [2:0]  q_kind;
  logic [7:0]  q_node;
  logic [9:0]  q_x;
  logic [9:0]  q_y;
  logic [20:0] q_dsq;
  logic [3:0]  q_slot;
  logic [62:0] q_ev;
  logic        q_member;
  logic        q_dead;

  logic [LW-1:0] hl;
  logic [LW-1:0] si;
  logic          pv;
  logic [HW-1:0] pidx;
  logic [20:0]   d;
  logic [NW-1:0] hsel;
  logic          multi;
  logic [2:0]    step;
  logic [63:0]   t;
  logic [63:0]   amp;
  logic [63:0]   acc;
  logic [63:0]   ch;
  logic [62:0]   rm;

  logic [62:0] emem [NODES];
  logic [62:0] erd;
  logic        e_re, e_we;
  logic [NW-1:0] e_raddr, e_waddr;
  logic [62:0] e_wdata;

  logic [HEW-1:0] hmem [HEADS];
  logic [HEW-1:0] hrd;
  logic           h_re, h_we;
  logic [HW-1:0]  h_raddr, h_waddr;

  logic        mul_go, mul_done;
  logic [63:0] mul_a, mul_b, mul_p;

  logic [NW-1:0] nidx;
  logic          inr, slot_ok, add_ok, go_cond, is_head;
  logic [NW-1:0] hrd_node;
  logic [9:0]    hrd_x, hrd_y, ad_x, ad_y;
  logic [20:0]   hrd_dsq;
  logic [19:0]   sq_x, sq_y;
  logic [20:0]   dcur;
  logic [62:0]   hnew, hfin;

  red_smul u_mul (
    .clk  (clk),
    .rst  (rst),
    .go   (mul_go),
    .a    (mul_a),
    .b    (mul_b),
    .done (mul_done),
    .p    (mul_p)
  );

  assign nidx     = NW'(q_node);
  assign inr      = int'(q_node) < NODES;
  assign slot_ok  = (int'(q_slot) < int'(hl)) && (int'(q_slot) < HEADS);
  assign add_ok   = inr && (int'(hl) < HEADS);
  assign is_head  = (q_kind == KIND_HDEBIT);
  assign go_cond  = inr && q_member && !q_dead && erd[62] && (|erd[61:0]) && (hl != '0);
  assign hrd_node = hrd[HEW-1:41];
  assign hrd_x    = hrd[40:31];
  assign hrd_y    = hrd[30:21];
  assign hrd_dsq  = hrd[20:0];
  assign ad_x     = (q_x >= hrd_x) ? q_x - hrd_x : hrd_x - q_x;
  assign ad_y     = (q_y >= hrd_y) ? q_y - hrd_y : hrd_y - q_y;
  assign sq_x     = 20'(ad_x) * 20'(ad_x);
  assign sq_y     = 20'(ad_y) * 20'(ad_y);
  assign dcur     = {1'b0, sq_x} + {1'b0, sq_y};
  assign hnew     = debit(erd, is_head ? acc : ch);
  assign hfin     = (d != '0) ? hnew : erd;

  assign busy       = (state != ST_IDLE);
  assign head_count = 5'(hl);

  always_ff @(posedge clk) begin
    if (e_we) emem[e_waddr] <= e_wdata;
    if (e_re) erd <= emem[e_raddr];
  end

  always_ff @(posedge clk) begin
    if (h_we) hmem[h_waddr] <= {nidx, q_x, q_y, q_dsq};
    if (h_re) hrd <= hmem[h_raddr];
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:    if (start) state_next = ST_DISP;
      ST_DISP: begin
        if (q_kind == KIND_HDEBIT) state_next = slot_ok ? ST_HEAD_RD : ST_OUT;
        else if (q_kind == KIND_MDEBIT || q_kind == KIND_READ) state_next = ST_EN_RD;
        else state_next = ST_OUT;
      end
      ST_HEAD_RD: state_next = ST_MUL_GO;
      ST_EN_RD:   state_next = (q_kind == KIND_MDEBIT && go_cond) ? ST_SCAN : ST_OUT;
      ST_SCAN:    if (si >= hl && !pv) state_next = ST_MUL_GO;
      ST_MUL_GO:  state_next = ST_MUL_WAIT;
      ST_MUL_WAIT: begin
        if (mul_done) begin
          if (is_head && step == 3'd6) state_next = ST_H_RD;
          else if (!is_head && step == 3'd5) state_next = ST_DEBIT1;
          else state_next = ST_MUL_GO;
        end
      end
      ST_DEBIT1:  state_next = ST_H_RD;
      ST_H_RD:    state_next = ST_H_WAIT;
      ST_H_WAIT:  state_next = ST_OUT;
      ST_OUT:     state_next = ST_IDLE;
      default:    state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    e_re    = 1'b0;
    e_raddr = nidx;
    e_we    = 1'b0;
    e_waddr = nidx;
    e_wdata = debit(rm, acc);
    h_re    = 1'b0;
    h_raddr = HW'(si);
    h_we    = 1'b0;
    h_waddr = HW'(hl);
    mul_go  = 1'b0;
    unique case (state)
      ST_DISP: begin
        case (q_kind)
          KIND_SET: begin
            e_we    = inr;
            e_wdata = q_ev ^ EN_FLOOR;
          end
          KIND_ADD:    h_we = add_ok;
          KIND_HDEBIT: begin
            h_re    = slot_ok;
            h_raddr = HW'(q_slot);
          end
          KIND_MDEBIT, KIND_READ: e_re = inr;
          default: ;
        endcase
      end
      ST_SCAN:   h_re = (si < hl);
      ST_MUL_GO: mul_go = 1'b1;
      ST_DEBIT1: e_we = 1'b1;
      ST_H_RD: begin
        e_re    = 1'b1;
        e_raddr = hsel;
      end
      ST_H_WAIT: begin
        e_we    = is_head || (d != '0);
        e_waddr = hsel;
        e_wdata = hnew;
      end
      default: ;
    endcase
  end

  always_comb begin
    mul_a = 64'(cfg.e_mp);
    mul_b = 64'(d);
    case (step)
      3'd1: begin
        mul_a = multi ? 64'(cfg.e_mp) : 64'(cfg.e_fs);
        mul_b = 64'(cfg.packet_bits);
      end
      3'd2: begin
        mul_a = t;
        mul_b = 64'(d);
      end
      3'd3: begin
        mul_a = t;
        mul_b = multi ? 64'(d) : 64'd1;
      end
      3'd4: begin
        mul_a = is_head ? 64'(cfg.e_tx) + 64'(cfg.e_da) : 64'(cfg.ctrl_packet_bits);
        mul_b = is_head ? 64'(cfg.packet_bits) : 64'(cfg.e_tx);
      end
      3'd5: begin
        mul_a = is_head ? 64'(cfg.ctrl_packet_bits) : 64'(cfg.e_rx) + 64'(cfg.e_da);
        mul_b = is_head ? 64'(cfg.e_rx) : 64'(cfg.packet_bits);
      end
      3'd6: begin
        mul_a = t;
        mul_b = 64'(cfg.rx_packets);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      hl    <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state == ST_OUT);
      if (state == ST_DISP) begin
        if (q_kind == KIND_ROUND) hl <= '0;
        else if (q_kind == KIND_ADD && add_ok) hl <= hl + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          q_kind   <= kind;
          q_node   <= node;
          q_x      <= x;
          q_y      <= y;
          q_dsq    <= dist_sq;
          q_slot   <= slot;
          q_ev     <= energy_value;
          q_member <= member;
          q_dead   <= dead;
        end
      end
      ST_DISP: begin
        node_out    <= q_node;
        energy      <= '0;
        head_node   <= '0;
        head_energy <= '0;
        updated     <= 1'b0;
        step        <= '0;
        si          <= '0;
        pv          <= 1'b0;
        case (q_kind)
          KIND_SET:                         if (inr) energy <= q_ev;
          KIND_ROUND, KIND_ADD, KIND_MDEBIT, KIND_READ: ;
          default:                          node_out <= '0;
        endcase
      end
      ST_HEAD_RD: begin
        d    <= hrd_dsq;
        hsel <= hrd_node;
      end
      ST_EN_RD: begin
        rm <= erd;
        if (!(q_kind == KIND_MDEBIT && go_cond)) energy <= inr ? (erd ^ EN_FLOOR) : '0;
      end
      ST_SCAN: begin
        if (si < hl) begin
          si   <= si + 1'b1;
          pv   <= 1'b1;
          pidx <= HW'(si);
        end else begin
          pv <= 1'b0;
        end
        if (pv && (pidx == '0 || dcur < d)) begin
          d    <= dcur;
          hsel <= hrd_node;
        end
      end
      ST_MUL_WAIT: begin
        if (mul_done) begin
          step <= step + 3'd1;
          case (step)
            3'd0: multi <= is_head ? (mul_p >= 64'(cfg.e_fs)) : (mul_p > 64'(cfg.e_fs));
            3'd1, 3'd2: t <= mul_p;
            3'd3: amp <= mul_p;
            3'd4: acc <= sadd(mul_p, amp);
            3'd5: begin
              if (is_head) t <= mul_p;
              else ch <= mul_p;
            end
            default: acc <= sadd(acc, mul_p);
          endcase
        end
      end
      ST_DEBIT1: rm <= debit(rm, acc);
      ST_H_WAIT: begin
        updated <= 1'b1;
        if (is_head) begin
          node_out <= 8'(hsel);
          energy   <= hnew ^ EN_FLOOR;
        end else begin
          head_node   <= 8'(hsel);
          head_energy <= hfin ^ EN_FLOOR;
          energy      <= (hsel == nidx) ? (hfin ^ EN_FLOOR) : (rm ^ EN_FLOOR);
        end
      end
      default: ;
    endcase
  end

endmodule
